FILE: rtl/core/pime_pkg.sv
// Shared types, codes and constants of the consensus message engine.
`default_nettype none

package pime_pkg;

  // Instance table geometry
  localparam int INST_W    = 13;
  localparam int INSTANCES = 1 << INST_W;
  localparam int NODE_W    = 7;

  // Field widths
  localparam int REQ_W    = 3;
  localparam int KIND_W   = 3;
  localparam int BALLOT_W = 32;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  // Ballot bump for a new round
  localparam logic [BALLOT_W-1:0] BALLOT_STEP = BALLOT_W'(100);
  localparam logic [BALLOT_W-1:0] NO_BALLOT   = '1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_START    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PREPARE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PROMISE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PROPOSE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ACCEPTED = 3'd4;
  localparam logic [REQ_W-1:0] REQ_LEARN    = 3'd5;

  // Outgoing word kinds
  localparam logic [KIND_W-1:0] KIND_PREPARE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PROMISE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PROPOSE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LEARN    = 3'd4;

  // Instance status codes
  localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_STARTUP  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_PROMISED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_ID  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT = 1'd1;

  // One instance table entry
  typedef struct packed {
    logic [BALLOT_W-1:0] ballot;
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  votes;
    logic [COUNT_W-1:0]  sent;
    logic [BALLOT_W-1:0] max_ballot;
    logic [VALUE_W-1:0]  max_value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One outgoing word
  typedef struct packed {
    logic [KIND_W-1:0]   out_kind;
    logic                is_broadcast;
    logic [NODE_W-1:0]   dest_node;
    logic [INST_W-1:0]   out_inst;
    logic [BALLOT_W-1:0] out_ballot;
    logic [VALUE_W-1:0]  out_value;
    logic [BALLOT_W-1:0] out_voted_ballot;
    logic [VALUE_W-1:0]  out_voted_value;
    logic                out_reject;
  } result_t;

  // One latched request
  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [NODE_W-1:0]   from_node;
    logic [INST_W-1:0]   idx;
    logic [BALLOT_W-1:0] ballot;
    logic [VALUE_W-1:0]  value;
    logic [BALLOT_W-1:0] voted_ballot;
    logic [VALUE_W-1:0]  voted_value;
    logic                rejected;
  } request_t;

endpackage

`default_nettype wire

FILE: rtl/core/pime_in_if.sv
// Request channel: one consensus message per word.
`default_nettype none

interface pime_in_if;
  logic                                valid;
  logic                                ready;
  logic [pime_pkg::REQ_W-1:0]          req_type;
  logic [pime_pkg::NODE_W-1:0]         from_node;
  logic [pime_pkg::INST_W-1:0]         inst_id;
  logic signed [pime_pkg::BALLOT_W-1:0] ballot;
  logic signed [pime_pkg::VALUE_W-1:0]  value;
  logic signed [pime_pkg::BALLOT_W-1:0] voted_ballot;
  logic signed [pime_pkg::VALUE_W-1:0]  voted_value;
  logic                                rejected;

  modport source (output valid, req_type, from_node, inst_id, ballot, value,
                  voted_ballot, voted_value, rejected, input ready);
  modport sink   (input valid, req_type, from_node, inst_id, ballot, value,
                  voted_ballot, voted_value, rejected, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pime_out_if.sv
// Result channel: one outgoing reply or broadcast per word.
`default_nettype none

interface pime_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [pime_pkg::KIND_W-1:0]          out_kind;
  logic                                 is_broadcast;
  logic [pime_pkg::NODE_W-1:0]          dest_node;
  logic [pime_pkg::INST_W-1:0]          out_inst;
  logic signed [pime_pkg::BALLOT_W-1:0] out_ballot;
  logic signed [pime_pkg::VALUE_W-1:0]  out_value;
  logic signed [pime_pkg::BALLOT_W-1:0] out_voted_ballot;
  logic signed [pime_pkg::VALUE_W-1:0]  out_voted_value;
  logic                                 out_reject;

  modport source (output valid, out_kind, is_broadcast, dest_node, out_inst, out_ballot,
                  out_value, out_voted_ballot, out_voted_value, out_reject, input ready);
  modport sink   (input valid, out_kind, is_broadcast, dest_node, out_inst, out_ballot,
                  out_value, out_voted_ballot, out_voted_value, out_reject, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pime_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none

interface pime_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pime_pkg::CFG_IDX_W-1:0] index;
  logic [pime_pkg::NODE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/paxos_instance_message_engine_top.sv
// Top level of the consensus message engine: sequencer, handlers and instance table.
`default_nettype none

// One message is taken at a time: the accept cycle reads the addressed instance entry
// from the table RAM, and the handler state that follows runs the handler, writes the
// entry back and loads the result register. A pending result that is not taken holds
// the handler state until the output register frees. After reset the table is swept to
// zero, one entry a cycle, over all INSTANCES (8192) entries, during which no message is
// accepted; configuration writes are taken at any time.
module paxos_instance_message_engine_top (
  input wire logic   clk,
  input wire logic   rst,
  pime_in_if.sink    in_ch,
  pime_out_if.source out_ch,
  pime_cfg_if.sink   cfg_ch
);

  // Sequencer codes
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [pime_pkg::INST_W-1:0] clear_addr;

  logic [pime_pkg::NODE_W-1:0] server_id;
  logic [pime_pkg::NODE_W-1:0] peer_count;

  logic                        cur_valid;
  logic [pime_pkg::INST_W-1:0] current_instance;
  logic [pime_pkg::INST_W-1:0] cur_advanced;
  logic [pime_pkg::VALUE_W-1:0] own_proposal;

  pime_pkg::request_t req;
  pime_pkg::result_t  res;
  pime_pkg::result_t  res_next;
  logic               out_valid;
  logic               has_res;

  pime_pkg::entry_t entry;
  pime_pkg::entry_t entry_next;
  logic             entry_we;
  logic             own_we;

  logic                        in_accept;
  logic                        exec_go;
  logic                        advance;
  logic [pime_pkg::INST_W-1:0] rd_addr;

  logic                        ram_we;
  logic [pime_pkg::INST_W-1:0] ram_waddr;
  logic [pime_pkg::ENTRY_W-1:0] ram_wdata;
  logic [pime_pkg::ENTRY_W-1:0] ram_rdata;

  // Handshakes
  assign in_ch.ready  = (state == ST_IDLE);
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign exec_go      = (state == ST_EXEC) && (!out_valid || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  // Instance counter step taken by start and learn
  assign cur_advanced = cur_valid ? current_instance + 1'b1 : '0;
  assign advance      = in_accept && ((in_ch.req_type == pime_pkg::REQ_START) ||
                                      (in_ch.req_type == pime_pkg::REQ_LEARN));
  assign rd_addr      = (in_ch.req_type == pime_pkg::REQ_START) ? cur_advanced
                                                                : in_ch.inst_id;

  // Instance table
  assign ram_we    = (state == ST_CLEAR) || (exec_go && entry_we);
  assign ram_waddr = (state == ST_CLEAR) ? clear_addr : req.idx;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : entry_next;
  assign entry     = pime_pkg::entry_t'(ram_rdata);

  pime_ram #(
    .WIDTH (pime_pkg::ENTRY_W),
    .DEPTH (pime_pkg::INSTANCES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clear_addr == pime_pkg::INST_W'(pime_pkg::INSTANCES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      server_id  <= '0;
      peer_count <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        pime_pkg::CFG_SERVER_ID:  server_id  <= cfg_ch.data;
        pime_pkg::CFG_PEER_COUNT: peer_count <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Request latch and instance counter
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req.req_type     <= in_ch.req_type;
      req.from_node    <= in_ch.from_node;
      req.idx          <= rd_addr;
      req.ballot       <= in_ch.ballot;
      req.value        <= in_ch.value;
      req.voted_ballot <= in_ch.voted_ballot;
      req.voted_value  <= in_ch.voted_value;
      req.rejected     <= in_ch.rejected;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid        <= 1'b0;
      current_instance <= '0;
      own_proposal     <= '0;
    end else begin
      if (advance) begin
        cur_valid        <= 1'b1;
        current_instance <= cur_advanced;
      end
      if (exec_go && own_we) begin
        own_proposal <= req.value;
      end
    end
  end

  // Message handlers
  logic [pime_pkg::BALLOT_W-1:0] new_ballot_base;
  logic [pime_pkg::BALLOT_W-1:0] new_ballot;
  logic [pime_pkg::COUNT_W-1:0]  votes_inc;
  logic [pime_pkg::COUNT_W-1:0]  round_sent;
  logic                          majority;
  logic                          take_vote;
  logic [pime_pkg::BALLOT_W-1:0] max_ballot_upd;
  logic [pime_pkg::VALUE_W-1:0]  max_value_upd;

  always_comb begin
    new_ballot_base = (req.req_type == pime_pkg::REQ_START) ? entry.ballot : req.ballot;
    new_ballot      = new_ballot_base + pime_pkg::BALLOT_STEP +
                      pime_pkg::BALLOT_W'(server_id);
    votes_inc       = entry.votes + 1'b1;
    round_sent      = pime_pkg::COUNT_W'(peer_count) + 1'b1;
    majority        = votes_inc > {1'b0, entry.sent[pime_pkg::COUNT_W-1:1]};
    take_vote       = (req.voted_ballot != pime_pkg::NO_BALLOT) &&
                      ($signed(entry.max_ballot) < $signed(req.ballot));
    max_ballot_upd  = take_vote ? req.voted_ballot : entry.max_ballot;
    max_value_upd   = take_vote ? req.voted_value : entry.max_value;

    entry_next = entry;
    entry_we   = 1'b0;
    own_we     = 1'b0;
    has_res    = 1'b0;

    res_next.out_kind         = pime_pkg::KIND_PREPARE;
    res_next.is_broadcast     = 1'b1;
    res_next.dest_node        = '0;
    res_next.out_inst         = req.idx;
    res_next.out_ballot       = new_ballot;
    res_next.out_value        = '0;
    res_next.out_voted_ballot = pime_pkg::NO_BALLOT;
    res_next.out_voted_value  = '0;
    res_next.out_reject       = 1'b0;

    unique case (req.req_type)
      pime_pkg::REQ_START: begin
        if (entry.status != pime_pkg::STATUS_PROMISED) begin
          own_we            = 1'b1;
          entry_we          = 1'b1;
          entry_next.status = pime_pkg::STATUS_STARTUP;
          entry_next.votes  = pime_pkg::COUNT_W'(1);
          entry_next.sent   = round_sent;
          has_res           = 1'b1;
        end
      end
      pime_pkg::REQ_PREPARE: begin
        has_res               = 1'b1;
        res_next.out_kind     = pime_pkg::KIND_PROMISE;
        res_next.is_broadcast = 1'b0;
        res_next.dest_node    = req.from_node;
        res_next.out_ballot   = req.ballot;
        if ($signed(entry.ballot) < $signed(req.ballot)) begin
          if (entry.status == pime_pkg::STATUS_ACCEPTED) begin
            res_next.out_voted_ballot = entry.ballot;
            res_next.out_voted_value  = entry.value;
          end
        end else begin
          res_next.out_reject = 1'b1;
        end
      end
      pime_pkg::REQ_PROMISE: begin
        if (req.rejected) begin
          // Rejected: open a new round with a higher ballot
          entry_we         = 1'b1;
          entry_next.votes = pime_pkg::COUNT_W'(1);
          entry_next.sent  = round_sent;
          has_res          = 1'b1;
        end else if (entry.status != pime_pkg::STATUS_PROMISED) begin
          entry_we              = 1'b1;
          entry_next.votes      = votes_inc;
          entry_next.max_ballot = max_ballot_upd;
          entry_next.max_value  = max_value_upd;
          if (majority) begin
            entry_next.status     = pime_pkg::STATUS_PROMISED;
            entry_next.votes      = pime_pkg::COUNT_W'(1);
            entry_next.sent       = round_sent;
            has_res               = 1'b1;
            res_next.out_kind     = pime_pkg::KIND_PROPOSE;
            if (req.voted_ballot != pime_pkg::NO_BALLOT) begin
              res_next.out_ballot = max_ballot_upd;
              res_next.out_value  = max_value_upd;
            end else begin
              res_next.out_ballot = req.ballot;
              res_next.out_value  = own_proposal;
            end
          end
        end
      end
      pime_pkg::REQ_PROPOSE: begin
        has_res               = 1'b1;
        res_next.out_kind     = pime_pkg::KIND_ACCEPTED;
        res_next.is_broadcast = 1'b0;
        res_next.dest_node    = req.from_node;
        if ($signed(entry.ballot) <= $signed(req.ballot)) begin
          entry_we            = 1'b1;
          entry_next.ballot   = req.ballot;
          entry_next.value    = req.value;
          res_next.out_ballot = req.ballot;
          res_next.out_value  = req.value;
        end else begin
          res_next.out_ballot = pime_pkg::NO_BALLOT;
        end
      end
      pime_pkg::REQ_ACCEPTED: begin
        if (entry.status != pime_pkg::STATUS_ACCEPTED) begin
          entry_we         = 1'b1;
          entry_next.votes = votes_inc;
          if (majority) begin
            entry_next.status   = pime_pkg::STATUS_ACCEPTED;
            entry_next.ballot   = req.ballot;
            entry_next.value    = req.value;
            has_res             = 1'b1;
            res_next.out_kind   = pime_pkg::KIND_LEARN;
            res_next.out_ballot = req.ballot;
            res_next.out_value  = req.value;
          end
        end
      end
      pime_pkg::REQ_LEARN: begin
        entry_we          = 1'b1;
        entry_next.status = pime_pkg::STATUS_ACCEPTED;
        entry_next.ballot = req.ballot;
        entry_next.value  = req.value;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (exec_go && has_res) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go && has_res) begin
      res <= res_next;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.out_kind         = res.out_kind;
  assign out_ch.is_broadcast     = res.is_broadcast;
  assign out_ch.dest_node        = res.dest_node;
  assign out_ch.out_inst         = res.out_inst;
  assign out_ch.out_ballot       = res.out_ballot;
  assign out_ch.out_value        = res.out_value;
  assign out_ch.out_voted_ballot = res.out_voted_ballot;
  assign out_ch.out_voted_value  = res.out_voted_value;
  assign out_ch.out_reject       = res.out_reject;

  // Checks
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_EXEC))
    else $error("accepted message did not reach the handler cycle");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EXEC))
    else $error("result appeared outside the handler cycle");

  a_write_when_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_EXEC))
    else $error("table written while idle");

  a_bcast_dest: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.is_broadcast) |-> (res.dest_node == '0 && res.out_reject == 1'b0))
    else $error("broadcast word carries a destination or reject flag");

endmodule

`default_nettype wire

FILE: rtl/core/pime_ram.sv
// Generic simple dual-port RAM with registered read and read enable.
`default_nettype none

module pime_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_paxos_instance_message_engine_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the consensus message engine: directed, stalled and random traffic.

module tb_paxos_instance_message_engine_top;

  // Covers the reset sweep plus every word seeing its longest gap and stall, several times over
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_TAIL  = 8;

  // Request codes the engine has no handler for
  localparam logic [pime_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [pime_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd7;

  localparam logic [pime_pkg::BALLOT_W-1:0] BALLOT_MAX = 32'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pime_in_if  in_ch ();
  pime_out_if out_ch ();
  pime_cfg_if cfg_ch ();

  paxos_instance_message_engine_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  // Mirror of the instance table and engine registers
  logic [pime_pkg::BALLOT_W-1:0] mdl_ballot     [pime_pkg::INSTANCES];
  logic [pime_pkg::VALUE_W-1:0]  mdl_value      [pime_pkg::INSTANCES];
  logic [pime_pkg::STATUS_W-1:0] mdl_status     [pime_pkg::INSTANCES];
  logic [pime_pkg::COUNT_W-1:0]  mdl_votes      [pime_pkg::INSTANCES];
  logic [pime_pkg::COUNT_W-1:0]  mdl_sent       [pime_pkg::INSTANCES];
  logic [pime_pkg::BALLOT_W-1:0] mdl_max_ballot [pime_pkg::INSTANCES];
  logic [pime_pkg::VALUE_W-1:0]  mdl_max_value  [pime_pkg::INSTANCES];
  bit                            mdl_cur_valid;
  logic [pime_pkg::INST_W-1:0]   mdl_cur;
  logic [pime_pkg::VALUE_W-1:0]  mdl_own;
  logic [pime_pkg::NODE_W-1:0]   mdl_server_id;
  logic [pime_pkg::NODE_W-1:0]   mdl_peers;

  pime_pkg::result_t replies_due [$];

  int err_cnt   = 0;
  int words_in  = 0;
  int cycle_cnt = 0;
  bit src_idle_on  = 1'b0;
  bit sink_idle_on = 1'b0;
  // Hold-off requests from the tests, and the ones the ready process has served
  int hold_req  = 0;
  int hold_done = 0;

  // ---------------------------------------------------------------- predictor

  task automatic model_clear();
    for (int i = 0; i < pime_pkg::INSTANCES; i++) begin
      mdl_ballot[i]     = '0;
      mdl_value[i]      = '0;
      mdl_status[i]     = pime_pkg::STATUS_NONE;
      mdl_votes[i]      = '0;
      mdl_sent[i]       = '0;
      mdl_max_ballot[i] = '0;
      mdl_max_value[i]  = '0;
    end
    mdl_cur_valid = 1'b0;
    mdl_cur       = '0;
    mdl_own       = '0;
    mdl_server_id = '0;
    mdl_peers     = '0;
  endtask

  function automatic logic [pime_pkg::BALLOT_W-1:0] bumped(
      input logic [pime_pkg::BALLOT_W-1:0] b);
    return b + pime_pkg::BALLOT_STEP + pime_pkg::BALLOT_W'(mdl_server_id);
  endfunction

  function automatic bit has_majority(input logic [pime_pkg::INST_W-1:0] i);
    return mdl_votes[i] > (mdl_sent[i] >> 1);
  endfunction

  task automatic open_round(input logic [pime_pkg::INST_W-1:0] i);
    mdl_votes[i] = 8'd1;
    mdl_sent[i]  = pime_pkg::COUNT_W'(mdl_peers) + 8'd1;
  endtask

  // none -> 0, then +1 with wrap at the table size
  task automatic advance_instance();
    if (!mdl_cur_valid) begin
      mdl_cur_valid = 1'b1;
      mdl_cur       = '0;
    end else begin
      mdl_cur = mdl_cur + 1'b1;
    end
  endtask

  // Apply one accepted message to the mirror; queue the word it should produce
  task automatic predict_reply(input pime_pkg::request_t rq);
    pime_pkg::result_t           r;
    bit                          hit;
    logic [pime_pkg::INST_W-1:0] i;
    r                  = '0;
    r.out_voted_ballot = pime_pkg::NO_BALLOT;
    r.out_inst         = rq.idx;
    r.dest_node        = rq.from_node;
    hit                = 1'b0;
    i                  = rq.idx;
    case (rq.req_type)
      pime_pkg::REQ_START: begin
        advance_instance();
        i = mdl_cur;
        if (mdl_status[i] != pime_pkg::STATUS_PROMISED) begin
          mdl_own       = rq.value;
          mdl_status[i] = pime_pkg::STATUS_STARTUP;
          open_round(i);
          r.out_kind     = pime_pkg::KIND_PREPARE;
          r.is_broadcast = 1'b1;
          r.out_inst     = i;
          r.out_ballot   = bumped(mdl_ballot[i]);
          hit            = 1'b1;
        end
      end
      pime_pkg::REQ_PREPARE: begin
        hit          = 1'b1;
        r.out_kind   = pime_pkg::KIND_PROMISE;
        r.out_ballot = rq.ballot;
        if ($signed(mdl_ballot[i]) < $signed(rq.ballot)) begin
          if (mdl_status[i] == pime_pkg::STATUS_ACCEPTED) begin
            r.out_voted_ballot = mdl_ballot[i];
            r.out_voted_value  = mdl_value[i];
          end
        end else begin
          r.out_reject = 1'b1;
        end
      end
      pime_pkg::REQ_PROMISE: begin
        if (rq.rejected) begin
          open_round(i);
          r.out_kind     = pime_pkg::KIND_PREPARE;
          r.is_broadcast = 1'b1;
          r.out_ballot   = bumped(rq.ballot);
          hit            = 1'b1;
        end else if (mdl_status[i] != pime_pkg::STATUS_PROMISED) begin
          mdl_votes[i] = mdl_votes[i] + 8'd1;
          if (rq.voted_ballot != pime_pkg::NO_BALLOT &&
              $signed(mdl_max_ballot[i]) < $signed(rq.ballot)) begin
            mdl_max_ballot[i] = rq.voted_ballot;
            mdl_max_value[i]  = rq.voted_value;
          end
          if (has_majority(i)) begin
            mdl_status[i]  = pime_pkg::STATUS_PROMISED;
            r.out_kind     = pime_pkg::KIND_PROPOSE;
            r.is_broadcast = 1'b1;
            r.out_ballot   = (rq.voted_ballot != pime_pkg::NO_BALLOT) ? mdl_max_ballot[i]
                                                                      : rq.ballot;
            r.out_value    = (rq.voted_ballot != pime_pkg::NO_BALLOT) ? mdl_max_value[i]
                                                                      : mdl_own;
            open_round(i);
            hit = 1'b1;
          end
        end
      end
      pime_pkg::REQ_PROPOSE: begin
        hit        = 1'b1;
        r.out_kind = pime_pkg::KIND_ACCEPTED;
        if ($signed(mdl_ballot[i]) <= $signed(rq.ballot)) begin
          mdl_ballot[i] = rq.ballot;
          mdl_value[i]  = rq.value;
          r.out_ballot  = rq.ballot;
          r.out_value   = rq.value;
        end else begin
          r.out_ballot = pime_pkg::NO_BALLOT;
        end
      end
      pime_pkg::REQ_ACCEPTED: begin
        if (mdl_status[i] != pime_pkg::STATUS_ACCEPTED) begin
          mdl_votes[i] = mdl_votes[i] + 8'd1;
          if (has_majority(i)) begin
            mdl_status[i]  = pime_pkg::STATUS_ACCEPTED;
            mdl_ballot[i]  = rq.ballot;
            mdl_value[i]   = rq.value;
            r.out_kind     = pime_pkg::KIND_LEARN;
            r.is_broadcast = 1'b1;
            r.out_ballot   = rq.ballot;
            r.out_value    = rq.value;
            hit            = 1'b1;
          end
        end
      end
      pime_pkg::REQ_LEARN: begin
        mdl_status[i] = pime_pkg::STATUS_ACCEPTED;
        mdl_ballot[i] = rq.ballot;
        mdl_value[i]  = rq.value;
        advance_instance();
      end
      default: ;
    endcase
    if (hit) begin
      if (r.is_broadcast) r.dest_node = '0;
      replies_due.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------- drivers

  // Offer one message word; returns at the edge it is taken
  task automatic send_msg(input logic [pime_pkg::REQ_W-1:0]    req,
                          input logic [pime_pkg::NODE_W-1:0]   from,
                          input logic [pime_pkg::INST_W-1:0]   inst,
                          input logic [pime_pkg::BALLOT_W-1:0] b,
                          input logic [pime_pkg::VALUE_W-1:0]  v,
                          input logic [pime_pkg::BALLOT_W-1:0] vb,
                          input logic [pime_pkg::VALUE_W-1:0]  vv,
                          input logic                          rej);
    pime_pkg::request_t rq;
    int                 gap;
    rq = '{req_type: req, from_node: from, idx: inst, ballot: b, value: v,
           voted_ballot: vb, voted_value: vv, rejected: rej};
    @(negedge clk);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      gap         = $urandom_range(1, 12);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.req_type     = rq.req_type;
    in_ch.from_node    = rq.from_node;
    in_ch.inst_id      = rq.idx;
    in_ch.ballot       = rq.ballot;
    in_ch.value        = rq.value;
    in_ch.voted_ballot = rq.voted_ballot;
    in_ch.voted_value  = rq.voted_value;
    in_ch.rejected     = rq.rejected;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_reply(rq);
    words_in++;
  endtask

  task automatic cfg_write(input logic [pime_pkg::CFG_IDX_W-1:0] reg_idx,
                           input logic [pime_pkg::NODE_W-1:0]    d);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = reg_idx;
    cfg_ch.data  = d;
    do @(posedge clk); while (!cfg_ch.ready);
    if (reg_idx == pime_pkg::CFG_SERVER_ID) mdl_server_id = d;
    else mdl_peers = d;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Stop offering, wait out every expected word and the handler cycle behind it
  task automatic wait_replies();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  function automatic logic [pime_pkg::BALLOT_W-1:0] rand_ballot();
    case ($urandom_range(0, 7))
      0:       return pime_pkg::NO_BALLOT;
      1:       return '0;
      2:       return BALLOT_MAX;
      3:       return pime_pkg::BALLOT_W'($urandom_range(0, 1000));
      default: return pime_pkg::BALLOT_W'($urandom) & BALLOT_MAX;
    endcase
  endfunction

  // Mostly a few hot entries so messages collide on one instance
  function automatic logic [pime_pkg::INST_W-1:0] rand_inst();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return pime_pkg::INST_W'(pime_pkg::INSTANCES - 1);
      2, 3:    return pime_pkg::INST_W'($urandom);
      default: return pime_pkg::INST_W'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic send_noise();
    send_msg(pime_pkg::REQ_W'($urandom_range(0, 7)), pime_pkg::NODE_W'($urandom),
             rand_inst(), rand_ballot(), $urandom, rand_ballot(), $urandom, 1'($urandom));
  endtask

  // One proposer round: start, promises, optional rival traffic and propose, accepts, maybe a learn
  task automatic run_round();
    logic [pime_pkg::INST_W-1:0]   c;
    logic [pime_pkg::BALLOT_W-1:0] b;
    logic [pime_pkg::VALUE_W-1:0]  v;
    int                            need;
    int                            n;
    send_msg(pime_pkg::REQ_START, pime_pkg::NODE_W'($urandom), rand_inst(), rand_ballot(),
             $urandom, rand_ballot(), $urandom, 1'($urandom));
    c    = mdl_cur;
    b    = bumped(mdl_ballot[c]);
    v    = $urandom;
    need = (int'(mdl_peers) + 1) / 2;
    n    = $urandom_range(need + 1, (need > 0) ? need - 1 : 0);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      send_msg(pime_pkg::REQ_PROMISE, pime_pkg::NODE_W'($urandom), c, b, $urandom,
               ($urandom_range(0, 2) == 0) ? rand_ballot() : pime_pkg::NO_BALLOT, $urandom,
               $urandom_range(0, 11) == 0);
    end
    if ($urandom_range(0, 2) == 0)
      send_msg(pime_pkg::REQ_PREPARE, pime_pkg::NODE_W'($urandom), c,
               b + pime_pkg::BALLOT_W'($urandom_range(0, 2)) - 1'b1,
               $urandom, rand_ballot(), $urandom, 1'($urandom));
    if ($urandom_range(0, 2) != 0)
      send_msg(pime_pkg::REQ_PROPOSE, pime_pkg::NODE_W'($urandom), c, b, v, rand_ballot(),
               $urandom, 1'($urandom));
    n = $urandom_range(need + 1, (need > 0) ? need - 1 : 0);
    repeat (n)
      send_msg(pime_pkg::REQ_ACCEPTED, pime_pkg::NODE_W'($urandom), c, b, v, rand_ballot(),
               $urandom, 1'($urandom));
    if ($urandom_range(0, 3) == 0)
      send_msg(pime_pkg::REQ_LEARN, pime_pkg::NODE_W'($urandom), c, b, v, rand_ballot(),
               $urandom, 1'($urandom));
  endtask

  // ---------------------------------------------------------------- result side

  // Random stalls; a long hold-off when requested
  initial begin : drive_ready
    int k;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done    = hold_req;
        out_ch.ready = 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        k            = $urandom_range(1, 12);
        repeat (k - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  function automatic void check_field(input string fname, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (want_v !== got_v) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("mismatch on %s: expected %h, got %h", fname, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin : check_replies
    pime_pkg::result_t got;
    pime_pkg::result_t want;
    if (out_ch.valid && out_ch.ready) begin
      got.out_kind         = out_ch.out_kind;
      got.is_broadcast     = out_ch.is_broadcast;
      got.dest_node        = out_ch.dest_node;
      got.out_inst         = out_ch.out_inst;
      got.out_ballot       = out_ch.out_ballot;
      got.out_value        = out_ch.out_value;
      got.out_voted_ballot = out_ch.out_voted_ballot;
      got.out_voted_value  = out_ch.out_voted_value;
      got.out_reject       = out_ch.out_reject;
      if (replies_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected word: kind %0d inst %0d ballot %h", got.out_kind,
                   got.out_inst, got.out_ballot);
      end else begin
        want = replies_due.pop_front();
        check_field("out_kind", 32'(want.out_kind), 32'(got.out_kind));
        check_field("is_broadcast", 32'(want.is_broadcast), 32'(got.is_broadcast));
        check_field("dest_node", 32'(want.dest_node), 32'(got.dest_node));
        check_field("out_inst", 32'(want.out_inst), 32'(got.out_inst));
        check_field("out_ballot", want.out_ballot, got.out_ballot);
        check_field("out_value", want.out_value, got.out_value);
        check_field("out_voted_ballot", want.out_voted_ballot, got.out_voted_ballot);
        check_field("out_voted_value", want.out_voted_value, got.out_voted_value);
        check_field("out_reject", 32'(want.out_reject), 32'(got.out_reject));
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_paxos_instance_message_engine_top: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    cfg_write(pime_pkg::CFG_SERVER_ID, 7'd5);
    cfg_write(pime_pkg::CFG_PEER_COUNT, 7'd2);
    // full round on instance 0: prepare, propose on majority, learn on majority
    send_msg(pime_pkg::REQ_START, 7'd0, 13'd0, '0, 32'h7FFF_FFFF, pime_pkg::NO_BALLOT, '0,
             1'b0);
    send_msg(pime_pkg::REQ_PROMISE, 7'd1, 13'd0, 32'd105, '0, pime_pkg::NO_BALLOT, '0, 1'b0);
    send_msg(pime_pkg::REQ_ACCEPTED, 7'd2, 13'd0, 32'd105, 32'h8000_0000,
             pime_pkg::NO_BALLOT, '0, 1'b0);
    // accepted on an entry already accepted
    send_msg(pime_pkg::REQ_ACCEPTED, 7'd3, 13'd0, 32'd105, 32'd1, pime_pkg::NO_BALLOT, '0,
             1'b0);
    // prepare above an accepted ballot reports the vote; at -1 it is rejected
    send_msg(pime_pkg::REQ_PREPARE, 7'd127, 13'd0, 32'd200, 32'hFFFF_FFFF,
             pime_pkg::NO_BALLOT, '0, 1'b0);
    send_msg(pime_pkg::REQ_PREPARE, 7'd0, 13'd0, pime_pkg::NO_BALLOT, '0,
             pime_pkg::NO_BALLOT, '0, 1'b0);
    // prepare on an unaccepted entry, then propose accepted and rejected
    send_msg(pime_pkg::REQ_PREPARE, 7'd127, 13'd8191, BALLOT_MAX, '0, BALLOT_MAX, '1, 1'b1);
    send_msg(pime_pkg::REQ_PROPOSE, 7'd64, 13'd8191, BALLOT_MAX, 32'h8000_0000,
             pime_pkg::NO_BALLOT, '0, 1'b0);
    send_msg(pime_pkg::REQ_PROPOSE, 7'd65, 13'd8191, '0, 32'h7FFF_FFFF,
             pime_pkg::NO_BALLOT, '0, 1'b0);
    // rejected promise re-prepares with a wrapping ballot
    send_msg(pime_pkg::REQ_PROMISE, 7'd9, 13'd3, BALLOT_MAX, '0, pime_pkg::NO_BALLOT, '0,
             1'b1);
    // promise carrying an earlier vote, then one on the promised entry
    send_msg(pime_pkg::REQ_PROMISE, 7'd10, 13'd3, 32'd16, '0, BALLOT_MAX, 32'hFFFF_FFFF,
             1'b0);
    send_msg(pime_pkg::REQ_PROMISE, 7'd11, 13'd3, 32'd17, '0, 32'd3, 32'd4, 1'b0);
    // start on instance 1, learn moves the counter to 2, start lands on promised 3
    send_msg(pime_pkg::REQ_START, 7'd0, 13'd0, '0, 32'hFFFF_FFFF, pime_pkg::NO_BALLOT, '0,
             1'b0);
    send_msg(pime_pkg::REQ_LEARN, 7'd12, 13'd1, 32'd7, 32'd9, pime_pkg::NO_BALLOT, '0, 1'b0);
    send_msg(pime_pkg::REQ_START, 7'd0, 13'd0, '0, 32'd55, pime_pkg::NO_BALLOT, '0, 1'b0);
    // unused request codes are dropped
    send_msg(REQ_SPARE_A, 7'd127, 13'd8191, '1, '1, '1, '1, 1'b1);
    send_msg(REQ_SPARE_B, 7'd127, 13'd8191, '1, '1, '1, '1, 1'b1);
    // start on 4, promise with a zero earlier vote, propose below the stored ballot
    send_msg(pime_pkg::REQ_START, 7'd0, 13'd0, '0, 32'd77, pime_pkg::NO_BALLOT, '0, 1'b0);
    send_msg(pime_pkg::REQ_PROMISE, 7'd13, 13'd4, 32'd105, '0, '0, 32'd1, 1'b0);
    send_msg(pime_pkg::REQ_PROPOSE, 7'd14, 13'd4, pime_pkg::NO_BALLOT, 32'd5,
             pime_pkg::NO_BALLOT, '0, 1'b0);
    wait_replies();
  endtask

  // Output held off while the sender keeps pushing, then drain before going on
  task automatic test_backpressure();
    hold_req++;
    repeat (24)
      send_msg(pime_pkg::REQ_PREPARE, pime_pkg::NODE_W'($urandom), rand_inst(),
               rand_ballot(), $urandom, rand_ballot(), $urandom, 1'($urandom));
    wait_replies();
  endtask

  task automatic test_random_rounds();
    logic [pime_pkg::NODE_W-1:0] sid;
    logic [pime_pkg::NODE_W-1:0] pc;
    int                          stop_at;
    for (int p = 0; p < 6; p++) begin
      wait_replies();
      case (p)
        0:       begin sid = '0; pc = '0; end
        1:       begin sid = '1; pc = '1; end
        2:       begin sid = pime_pkg::NODE_W'($urandom); pc = 7'd1; end
        3:       begin sid = pime_pkg::NODE_W'($urandom); pc = 7'd2; end
        4:       begin sid = pime_pkg::NODE_W'($urandom); pc = 7'd4; end
        default: begin
          sid = pime_pkg::NODE_W'($urandom);
          pc  = pime_pkg::NODE_W'($urandom_range(0, 9));
        end
      endcase
      cfg_write(pime_pkg::CFG_SERVER_ID, sid);
      cfg_write(pime_pkg::CFG_PEER_COUNT, pc);
      stop_at = words_in + 80;
      while (words_in < stop_at) begin
        run_round();
        repeat ($urandom_range(0, 3)) send_noise();
      end
    end
    wait_replies();
  endtask

  // Last stretch with no idling on either side
  task automatic test_instance_wrap();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (3) run_round();
    wait_replies();
  endtask

  initial begin : run_tests
    in_ch.valid        = 1'b0;
    in_ch.req_type     = pime_pkg::REQ_START;
    in_ch.from_node    = '0;
    in_ch.inst_id      = '0;
    in_ch.ballot       = '0;
    in_ch.value        = '0;
    in_ch.voted_ballot = '0;
    in_ch.voted_value  = '0;
    in_ch.rejected     = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = pime_pkg::CFG_SERVER_ID;
    cfg_ch.data        = '0;
    model_clear();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst          = 1'b0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    test_directed();
    test_backpressure();
    test_random_rounds();
    test_instance_wrap();
    if (err_cnt == 0 && replies_due.size() == 0) begin
      $display("tb_paxos_instance_message_engine_top: done, clean");
    end else begin
      $display("tb_paxos_instance_message_engine_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pime_pkg.sv
rtl/core/pime_in_if.sv
rtl/core/pime_out_if.sv
rtl/core/pime_cfg_if.sv
rtl/core/pime_ram.sv
rtl/core/paxos_instance_message_engine_top.sv
dv/tb_paxos_instance_message_engine_top.sv
